// ===== rtl/pip_pkg.sv =====
package pip_pkg;

    // Default sizes of the vertex table and of one coordinate.
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 16;

    // A polygon needs at least this many stored vertices before a test is made.
    localparam int MIN_TEST_VERTICES = 4;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FEW  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    // Item function codes.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_TEST   = 1'b1;

endpackage

// ===== rtl/point_in_polygon_tester.sv =====
// Point-in-polygon tester using ray casting with the even-odd rule. An append
// item (func 0) stores one vertex unless full, restart first empties the
// table, and its result strobes on the cycle after it is taken; busy is not
// raised. A test item (func 1) that finds fewer than four vertices, or a
// point outside the half-open bounding box, also answers on the next cycle.
// Otherwise the block walks every edge through the single read port of the
// vertex memory, one vertex per cycle, and a shared pair of cross-multipliers
// compares each edge crossing with the point: busy stays high through the
// walk, and the result strobes in the same cycle that busy falls. The result
// is shown on inside_res and status for exactly one cycle while result_valid
// is high; there is no way to hold it, so the receiver must take it then. A
// new item may be started in that same cycle.
module point_in_polygon_tester #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic                          restart,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    output logic                          result_valid,
    output logic                          inside_res,
    output pip_pkg::status_t              status
);
    import pip_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    localparam logic signed [COORD_BITS-1:0] BOX_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] BOX_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Control state.
    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_active_reg, rd_active_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             rd_first_reg, rd_first_next;
    logic             rd_last_reg, rd_last_next;
    logic             e_vld_reg, e_vld_next;
    logic             e_last_reg, e_last_next;
    logic             m_vld_reg, m_vld_next;
    logic             m_last_reg, m_last_next;
    logic             parity_reg, parity_next;
    logic             strobe_reg, strobe_next;
    logic             inside_reg, inside_next;
    status_t          status_reg, status_next;

    logic signed [COORD_BITS-1:0] box_min_x_reg, box_min_x_next;
    logic signed [COORD_BITS-1:0] box_min_y_reg, box_min_y_next;
    logic signed [COORD_BITS-1:0] box_max_x_reg, box_max_x_next;
    logic signed [COORD_BITS-1:0] box_max_y_reg, box_max_y_next;

    // Datapath registers.
    logic [2*COORD_BITS-1:0]      vtx_mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0]      mem_q_reg;
    logic [2*COORD_BITS-1:0]      prev_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [DW-1:0]         d1_reg, d2_reg, d3_reg, d4_reg;
    logic                         e_span_reg, m_span_reg;
    logic signed [PW-1:0]         p1_reg, p2_reg;

    // Combinational helpers.
    logic                         accept;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [CNT_W-1:0]             eff_count;
    logic signed [COORD_BITS-1:0] base_min_x, base_min_y, base_max_x, base_max_y;
    logic                         out_of_box;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cur_x, cur_y, old_x, old_y;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign result_valid = strobe_reg;
    assign inside_res   = inside_reg;
    assign status       = status_reg;

    // Table fill seen by an append, after an optional restart.
    assign eff_count  = restart ? '0 : count_reg;
    assign base_min_x = restart ? BOX_TOP : box_min_x_reg;
    assign base_min_y = restart ? BOX_TOP : box_min_y_reg;
    assign base_max_x = restart ? BOX_BOT : box_max_x_reg;
    assign base_max_y = restart ? BOX_BOT : box_max_y_reg;

    assign wr_en   = accept && (func == FUNC_APPEND) && (eff_count < CNT_W'(MAX_VERTICES));
    assign wr_addr = eff_count[AW-1:0];

    // The walk reads vertices 0 to n-1 and then vertex 0 again to close the ring.
    assign rd_addr = (rd_cnt_reg == count_reg) ? '0 : rd_cnt_reg[AW-1:0];

    // Half-open bounding box check of the incoming point.
    assign out_of_box = (coord_x < box_min_x_reg) || (coord_x >= box_max_x_reg) ||
                        (coord_y < box_min_y_reg) || (coord_y >= box_max_y_reg);

    // Edge end points, ordered so that a has the lower y.
    assign cur_x = mem_q_reg[COORD_BITS-1:0];
    assign cur_y = mem_q_reg[2*COORD_BITS-1:COORD_BITS];
    assign old_x = prev_reg[COORD_BITS-1:0];
    assign old_y = prev_reg[2*COORD_BITS-1:COORD_BITS];

    always_comb
    begin
        if (old_y > cur_y)
        begin
            ax = cur_x;
            ay = cur_y;
            bx = old_x;
            by = old_y;
        end
        else
        begin
            ax = old_x;
            ay = old_y;
            bx = cur_x;
            by = cur_y;
        end
    end

    // The crossing lies right of the point when (px-ax)*(by-ay) < (py-ay)*(bx-ax).
    assign hit = m_span_reg && (p1_reg < p2_reg);

    // Sequencer and table bookkeeping.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_active_next = rd_active_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_first_next  = rd_first_reg;
        rd_last_next   = rd_last_reg;
        e_vld_next     = rd_vld_reg && !rd_first_reg;
        e_last_next    = rd_last_reg;
        m_vld_next     = e_vld_reg;
        m_last_next    = e_last_reg;
        parity_next    = parity_reg;
        strobe_next    = 1'b0;
        inside_next    = 1'b0;
        status_next    = ST_OK;
        box_min_x_next = box_min_x_reg;
        box_min_y_next = box_min_y_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;

        if (accept)
        begin
            if (func == FUNC_APPEND)
            begin
                strobe_next = 1'b1;
                if (eff_count >= CNT_W'(MAX_VERTICES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next     = eff_count + CNT_W'(1);
                    box_min_x_next = (coord_x < base_min_x) ? coord_x : base_min_x;
                    box_min_y_next = (coord_y < base_min_y) ? coord_y : base_min_y;
                    box_max_x_next = (coord_x > base_max_x) ? coord_x : base_max_x;
                    box_max_y_next = (coord_y > base_max_y) ? coord_y : base_max_y;
                end
            end
            else if (count_reg < CNT_W'(MIN_TEST_VERTICES))
            begin
                strobe_next = 1'b1;
                status_next = ST_FEW;
            end
            else if (out_of_box)
            begin
                strobe_next = 1'b1;
            end
            else
            begin
                state_next     = S_WALK;
                rd_active_next = 1'b1;
                rd_cnt_next    = '0;
                parity_next    = 1'b0;
            end
        end

        if (state_reg == S_WALK)
        begin
            // Issue one memory read per cycle until the ring is closed.
            if (rd_active_reg)
            begin
                rd_vld_next   = 1'b1;
                rd_first_next = (rd_cnt_reg == '0);
                rd_last_next  = (rd_cnt_reg == count_reg);
                if (rd_cnt_reg == count_reg)
                begin
                    rd_active_next = 1'b0;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
            end

            // Count crossings and finish on the closing edge.
            if (m_vld_reg)
            begin
                parity_next = parity_reg ^ hit;
                if (m_last_reg)
                begin
                    strobe_next = 1'b1;
                    inside_next = parity_reg ^ hit;
                    state_next  = S_IDLE;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_active_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            e_vld_reg     <= 1'b0;
            e_last_reg    <= 1'b0;
            m_vld_reg     <= 1'b0;
            m_last_reg    <= 1'b0;
            parity_reg    <= 1'b0;
            strobe_reg    <= 1'b0;
            inside_reg    <= 1'b0;
            status_reg    <= ST_OK;
            box_min_x_reg <= BOX_TOP;
            box_min_y_reg <= BOX_TOP;
            box_max_x_reg <= BOX_BOT;
            box_max_y_reg <= BOX_BOT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_active_reg <= rd_active_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            rd_first_reg  <= rd_first_next;
            rd_last_reg   <= rd_last_next;
            e_vld_reg     <= e_vld_next;
            e_last_reg    <= e_last_next;
            m_vld_reg     <= m_vld_next;
            m_last_reg    <= m_last_next;
            parity_reg    <= parity_next;
            strobe_reg    <= strobe_next;
            inside_reg    <= inside_next;
            status_reg    <= status_next;
            box_min_x_reg <= box_min_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_x_reg <= box_max_x_next;
            box_max_y_reg <= box_max_y_next;
        end
    end

    // Vertex memory: one write port for appends, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vtx_mem[wr_addr] <= {coord_y, coord_x};
        end
        mem_q_reg <= vtx_mem[rd_addr];
    end

    // Edge pipeline: differences, then the two cross products.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_vld_reg)
        begin
            prev_reg   <= mem_q_reg;
            d1_reg     <= DW'(px_reg) - DW'(ax);
            d2_reg     <= DW'(by) - DW'(ay);
            d3_reg     <= DW'(py_reg) - DW'(ay);
            d4_reg     <= DW'(bx) - DW'(ax);
            e_span_reg <= (ay < py_reg) && (py_reg < by);
        end
        p1_reg     <= PW'(d1_reg) * PW'(d2_reg);
        p2_reg     <= PW'(d3_reg) * PW'(d4_reg);
        m_span_reg <= e_span_reg;
    end

endmodule

// ===== tb/point_in_polygon_tester_checker.sv =====
`timescale 1ns / 100ps

// Watches both sides of the point-in-polygon tester, keeps its own copy of the
// vertex table and bounding box, and checks every result strobe against the
// oldest outstanding prediction.
module point_in_polygon_tester_checker #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          func,
    input  logic                          restart,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic                          result_valid,
    input  logic                          inside_res,
    input  pip_pkg::status_t              status,
    output int                            errors,
    output int                            waiting,
    output int                            inside_count,
    output int                            few_count,
    output int                            full_count
);
    import pip_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic    in_poly;
        status_t status;
    } verdict_t;

    localparam coord_t COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Shadow copy of the polygon held by the block.
    coord_t      vert_x [MAX_VERTICES];
    coord_t      vert_y [MAX_VERTICES];
    int unsigned vert_total;
    coord_t      min_x, min_y, max_x, max_y;

    verdict_t pending_verdicts [$];
    verdict_t predicted, oldest;

    int error_total  = 0;
    int inside_total = 0;
    int few_total    = 0;
    int full_total   = 0;
    int queue_depth  = 0;

    assign errors       = error_total;
    assign waiting      = queue_depth;
    assign inside_count = inside_total;
    assign few_count    = few_total;
    assign full_count   = full_total;

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_total++;
    endtask

    // Add a prediction at the tail of the outstanding list.
    task automatic enqueue_verdict(verdict_t v);
        pending_verdicts = {pending_verdicts, v};
    endtask

    // Empty the table and open the box out to its reset extremes.
    function automatic void clear_polygon();
        vert_total = 0;
        min_x = COORD_TOP;
        min_y = COORD_TOP;
        max_x = COORD_BOTTOM;
        max_y = COORD_BOTTOM;
    endfunction

    // True when the edge from a to b crosses the ray cast towards +x from p.
    // The crossing is compared by cross-multiplication, so no division and no
    // trouble with vertical edges.
    function automatic logic edge_hit(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
        longint t;
        if (ay > by)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        if (!(ay < py && py < by))
            return 1'b0;
        return (px - ax) * (by - ay) < (py - ay) * (bx - ax);
    endfunction

    // Even-odd rule over every edge, the last one wrapping to the first vertex.
    function automatic logic point_inside(coord_t px, coord_t py);
        logic        parity;
        int unsigned i;
        int unsigned nxt;
        parity = 1'b0;
        if (px < min_x || px >= max_x || py < min_y || py >= max_y)
            return 1'b0;
        for (i = 0; i < vert_total; i++)
        begin
            nxt = (i + 1 == vert_total) ? 0 : i + 1;
            parity ^= edge_hit(px, py, vert_x[i], vert_y[i], vert_x[nxt], vert_y[nxt]);
        end
        return parity;
    endfunction

    // Work out the result of one accepted item and update the shadow state.
    function automatic verdict_t predict_item(logic f, logic rs, coord_t x, coord_t y);
        verdict_t v;
        v.in_poly = 1'b0;
        v.status  = ST_OK;
        if (f == FUNC_APPEND)
        begin
            if (rs)
                clear_polygon();
            if (vert_total >= MAX_VERTICES)
                v.status = ST_FULL;
            else
            begin
                vert_x[vert_total] = x;
                vert_y[vert_total] = y;
                vert_total++;
                if (x < min_x) min_x = x;
                if (y < min_y) min_y = y;
                if (x > max_x) max_x = x;
                if (y > max_y) max_y = y;
            end
        end
        else if (vert_total < MIN_TEST_VERTICES)
            v.status = ST_FEW;
        else
            v.in_poly = point_inside(x, y);
        return v;
    endfunction

    // Results are checked before the item taken at the same edge is predicted,
    // since a result can never belong to an item accepted at that same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_polygon();
            pending_verdicts.delete();
            queue_depth = 0;
        end
        else
        begin
            if (result_valid === 1'b1)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("result strobe with no item outstanding");
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    if (inside_res !== oldest.in_poly)
                        report_mismatch($sformatf("inside_res expected %0b, got %0b",
                                                  oldest.in_poly, inside_res));
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status expected %0d, got %0d",
                                                  oldest.status, status));
                end
            end
            else if (result_valid !== 1'b0)
                report_mismatch("result strobe is unknown");

            if (start === 1'b1 && busy === 1'b0)
            begin
                predicted = predict_item(func, restart, coord_x, coord_y);
                enqueue_verdict(predicted);
                if (predicted.in_poly)
                    inside_total++;
                if (predicted.status == ST_FEW)
                    few_total++;
                if (predicted.status == ST_FULL)
                    full_total++;
            end
            queue_depth = pending_verdicts.size();
        end
    end

endmodule

// ===== tb/point_in_polygon_tester_tb.sv =====
`timescale 1ns / 100ps

module point_in_polygon_tester_tb;
    import pip_pkg::*;

    localparam int ITEM_GOAL   = 550;
    localparam int QUIET_TAIL  = 80;
    localparam int TAIL_CYCLES = 80;
    localparam int FULL_RANGE  = 65535;
    localparam int COORD_MIN   = -32768;
    localparam int COORD_MAX   = 32767;

    logic                                clk     = 1'b0;
    logic                                rst_n   = 1'b0;
    logic                                start   = 1'b0;
    logic                                func    = FUNC_APPEND;
    logic                                restart = 1'b0;
    logic signed [DEF_COORD_BITS-1:0]    coord_x = '0;
    logic signed [DEF_COORD_BITS-1:0]    coord_y = '0;
    logic                                busy;
    logic                                result_valid;
    logic                                inside_res;
    status_t                             status;

    int errors, waiting, inside_count, few_count, full_count;
    int items_sent = 0;

    // Current drawing frame for a polygon: lower corner and spread per axis.
    int frame_x, frame_y, spread_x, spread_y;

    point_in_polygon_tester dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .restart      (restart),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .result_valid (result_valid),
        .inside_res   (inside_res),
        .status       (status)
    );

    point_in_polygon_tester_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .restart      (restart),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .result_valid (result_valid),
        .inside_res   (inside_res),
        .status       (status),
        .errors       (errors),
        .waiting      (waiting),
        .inside_count (inside_count),
        .few_count    (few_count),
        .full_count   (full_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Safety net in case the block hangs or a result never arrives.
    initial
    begin
        #5_000_000;
        $display("point_in_polygon_tester_tb: errors");
        $finish;
    end

    // Drop start for a burst of cycles, with junk on the payload meanwhile.
    task automatic hold_off(int cycles);
        @(negedge clk);
        start   <= 1'b0;
        func    <= 1'($urandom_range(0, 1));
        restart <= 1'($urandom_range(0, 1));
        coord_x <= 16'($urandom_range(0, FULL_RANGE));
        coord_y <= 16'($urandom_range(0, FULL_RANGE));
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Present one item and hold it until the block takes it. Start stays high
    // afterwards so that a following item can go in back to back.
    task automatic send_item(logic f, logic rs, int x, int y);
        @(negedge clk);
        start   <= 1'b1;
        func    <= f;
        restart <= rs;
        coord_x <= x[15:0];
        coord_y <= y[15:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
        if (items_sent < ITEM_GOAL - QUIET_TAIL && $urandom_range(0, 99) < 25)
            hold_off($urandom_range(1, 19));
    endtask

    // Stop sending and wait until every outstanding item has answered.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    // Pick a fresh frame: a tiny grid, a medium patch or the full range.
    task automatic new_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            spread_x = $urandom_range(2, 8);
            spread_y = $urandom_range(2, 8);
        end
        else if (r < 80)
        begin
            spread_x = $urandom_range(20, 2000);
            spread_y = $urandom_range(20, 2000);
        end
        else
        begin
            spread_x = FULL_RANGE;
            spread_y = FULL_RANGE;
        end
        frame_x = COORD_MIN + $urandom_range(0, FULL_RANGE - spread_x);
        frame_y = COORD_MIN + $urandom_range(0, FULL_RANGE - spread_y);
    endtask

    // A well-formed polygon with random content, followed by a few tests.
    // Test points reach one step past the frame so the box edges get hit.
    task automatic polygon_run();
        int r, n, k;
        new_frame();
        r = $urandom_range(0, 99);
        if (r < 65)
            n = $urandom_range(4, 8);
        else if (r < 85)
            n = $urandom_range(9, 24);
        else if (r < 95)
            n = $urandom_range(1, 3);
        else
            n = DEF_MAX_VERTICES;
        for (k = 0; k < n; k++)
        begin
            send_item(FUNC_APPEND, k == 0, frame_x + $urandom_range(0, spread_x),
                      frame_y + $urandom_range(0, spread_y));
            if ($urandom_range(0, 99) < 4)
                send_item(FUNC_TEST, 1'($urandom_range(0, 1)),
                          frame_x + $urandom_range(0, spread_x),
                          frame_y + $urandom_range(0, spread_y));
        end
        // Appends beyond a full table must be refused.
        if (n == DEF_MAX_VERTICES)
            repeat ($urandom_range(1, 3))
                send_item(FUNC_APPEND, 1'b0, $urandom_range(0, FULL_RANGE),
                          $urandom_range(0, FULL_RANGE));
        repeat ($urandom_range(1, 8))
            send_item(FUNC_TEST, 1'($urandom_range(0, 1)),
                      frame_x - 1 + $urandom_range(0, spread_x + 2),
                      frame_y - 1 + $urandom_range(0, spread_y + 2));
    endtask

    // Unstructured items, restarts and stray appends included.
    task automatic noise_run();
        repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, FULL_RANGE), $urandom_range(0, FULL_RANGE));
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // A test on an empty table, then a square spanning the whole range.
        send_item(FUNC_TEST,   1'b0, 0, 0);
        send_item(FUNC_APPEND, 1'b1, COORD_MIN, COORD_MIN);
        send_item(FUNC_APPEND, 1'b0, COORD_MAX, COORD_MIN);
        send_item(FUNC_APPEND, 1'b0, COORD_MAX, COORD_MAX);
        send_item(FUNC_TEST,   1'b0, 0, 0);
        send_item(FUNC_APPEND, 1'b0, COORD_MIN, COORD_MAX);
        send_item(FUNC_TEST,   1'b1, 0, 0);
        send_item(FUNC_TEST,   1'b0, COORD_MIN, 0);
        send_item(FUNC_TEST,   1'b0, COORD_MAX, 0);
        send_item(FUNC_TEST,   1'b0, 0, COORD_MAX);
        send_item(FUNC_TEST,   1'b0, 0, COORD_MIN);
        send_item(FUNC_TEST,   1'b0, COORD_MAX - 1, COORD_MAX - 1);
        send_item(FUNC_TEST,   1'b0, COORD_MIN, COORD_MIN);

        // A concave pentagon with horizontal and vertical edges; points on a
        // vertex, on edges and in the notch.
        send_item(FUNC_APPEND, 1'b1, 0, 0);
        send_item(FUNC_APPEND, 1'b0, 10, 0);
        send_item(FUNC_APPEND, 1'b0, 10, 10);
        send_item(FUNC_APPEND, 1'b0, 5, 5);
        send_item(FUNC_APPEND, 1'b0, 0, 10);
        send_item(FUNC_TEST,   1'b0, 5, 5);
        send_item(FUNC_TEST,   1'b0, 0, 5);
        send_item(FUNC_TEST,   1'b0, 5, 0);
        send_item(FUNC_TEST,   1'b0, 5, 8);
        send_item(FUNC_TEST,   1'b0, 2, 8);
        send_item(FUNC_TEST,   1'b0, 9, 2);
        drain_results();

        // Random part, mostly well-formed polygons with some noise between.
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 99) < 80)
                polygon_run();
            else
                noise_run();
            if (items_sent < ITEM_GOAL - QUIET_TAIL && $urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d tests inside, %0d tests with too few vertices,",
                 items_sent, inside_count, few_count);
        $display("and %0d appends hit a full table, over grids, patches and the full range.",
                 full_count);
        if (errors == 0)
            $display("point_in_polygon_tester_tb: clean");
        else
            $display("point_in_polygon_tester_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pip_pkg.sv
rtl/point_in_polygon_tester.sv
tb/point_in_polygon_tester_checker.sv
tb/point_in_polygon_tester_tb.sv
